/* rtl/rect_tilemap_collision_core_assert.svh */
// Assertion macros shared by the checker of the tile-map collision core.
// Each macro expands to one labeled concurrent assertion, reset-qualified.
`ifndef RECT_TILEMAP_COLLISION_CORE_ASSERT_SVH
`define RECT_TILEMAP_COLLISION_CORE_ASSERT_SVH

// same-cycle implication
`define RTC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rtc_pkg.sv */
// Types and constants of the tile-map collision core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    localparam int COORD_W     = 12;
    localparam int DIM_W       = 8;
    localparam int TIDX_W      = 4;
    localparam int MAPSZ_W     = 5;
    localparam int LIM_W       = 7;    // holds map limits up to 127
    localparam int CELL_W      = 13;   // neighbour index, quotient plus one
    localparam int CMP_W       = 14;   // pixel edges of rectangle and tiles
    localparam int DIV_CNT_W   = 4;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] NBR_LAST = 2'd2;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_TILE_WIDTH  = 2'd0,
        REG_TILE_HEIGHT = 2'd1,
        REG_MAP_COLS    = 2'd2,
        REG_MAP_ROWS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic [DIM_W-1:0]   tile_w;
        logic [DIM_W-1:0]   tile_h;
        logic [MAPSZ_W-1:0] map_cols;
        logic [MAPSZ_W-1:0] map_rows;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] rect_x;
        logic [COORD_W-1:0] rect_y;
        logic [DIM_W-1:0]   rect_w;
        logic [DIM_W-1:0]   rect_h;
        logic [TIDX_W-1:0]  tile_row;
        logic [TIDX_W-1:0]  tile_col;
        logic               tile_solid;
    } cmd_t;

    typedef struct packed {
        logic cmd_ready;
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

/* rtl/rtc_front.sv */
// Front end: takes input transactions, classifies them and queues commands.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtc_front #(
    parameter int MAX_MAP_ROWS = 16,
    parameter int MAX_MAP_COLS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rtc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire rtc_pkg::back_status_t           status,
    output logic                                 cmd_valid,
    output rtc_pkg::cmd_t                        cmd
);
    import rtc_pkg::*;

    cmd_t                q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    cmd_t                in_cmd;
    logic                accept;
    logic                drop;
    logic                enq;
    logic                deq;

    always_comb
    begin
        in_cmd.op         = op_t'(s_tuser);
        in_cmd.rect_x     = s_tdata[11:0];
        in_cmd.rect_y     = s_tdata[23:12];
        in_cmd.rect_w     = s_tdata[31:24];
        in_cmd.rect_h     = s_tdata[39:32];
        in_cmd.tile_row   = s_tdata[43:40];
        in_cmd.tile_col   = s_tdata[47:44];
        in_cmd.tile_solid = s_tdata[48];
    end

    // writes beyond the stored map have no effect and are not queued
    assign drop = (in_cmd.op == OP_WRITE) &&
                  ((LIM_W'(in_cmd.tile_row) >= LIM_W'(MAX_MAP_ROWS)) ||
                   (LIM_W'(in_cmd.tile_col) >= LIM_W'(MAX_MAP_COLS)));

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH)) && !status.clearing;
    assign accept    = s_tvalid && s_tready;
    assign enq       = accept && !drop;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign deq       = cmd_valid && status.cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/rtc_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [rtc_pkg::COORD_W-1:0]   dividend,
    input  wire logic [rtc_pkg::DIM_W-1:0]     divisor,
    output logic                               busy,
    output logic [rtc_pkg::COORD_W-1:0]        quotient
);
    import rtc_pkg::*;

    logic [COORD_W-1:0]   quo_reg, quo_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [DIM_W-1:0]     div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DIM_W:0]       rem_sh;
    logic [DIM_W:0]       rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, quo_reg[COORD_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign fits    = (rem_sh >= {1'b0, div_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        priority if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[COORD_W-2:0], fits};
            rem_next = fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(COORD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* rtl/rtc_back.sv */
// Back end: tile map memory, clearing pass, query engine and result register.
// Depends on rtc_pkg and rtc_div.
`timescale 1ns / 1ps
`default_nettype none

module rtc_back #(
    parameter int MAX_MAP_ROWS = 16,
    parameter int MAX_MAP_COLS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire rtc_pkg::cfg_t          cfg,
    input  wire logic                   cmd_valid,
    input  wire rtc_pkg::cmd_t          cmd,
    output rtc_pkg::back_status_t       status,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic                        m_hit
);
    import rtc_pkg::*;

    // tile inputs are 4 bits wide, so at most 16 x 16 tiles can ever be written
    localparam int STORE_ROWS = (MAX_MAP_ROWS < 16) ? MAX_MAP_ROWS : 16;
    localparam int STORE_COLS = (MAX_MAP_COLS < 16) ? MAX_MAP_COLS : 16;
    localparam int DEPTH      = STORE_ROWS * STORE_COLS;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW         = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
    localparam int CW         = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;

    back_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [1:0]           dr_reg, dr_next;
    logic [1:0]           dc_reg, dc_next;
    logic                 chk_pend_reg, chk_pend_next;
    logic                 hit_acc_reg, hit_acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg, hit_next;

    logic [COORD_W-1:0]   qx_reg, qy_reg;
    logic [DIM_W-1:0]     qw_reg, qh_reg;
    logic                 zero_reg;
    logic                 chk_in_reg;
    logic [CMP_W-1:0]     x0_reg, y0_reg;
    logic                 rd_data_reg;

    logic                 mem [DEPTH];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic                 mem_wdata;
    logic [ADDR_W-1:0]    rd_addr;

    logic                 div_start;
    logic                 x_busy, y_busy;
    logic [COORD_W-1:0]   cx, cy;

    logic                 take_query;
    logic [LIM_W-1:0]     rows_lim, cols_lim;
    logic [CELL_W-1:0]    rr, cc, rr_m1, cc_m1;
    logic [RW-1:0]        r_idx;
    logic [CW-1:0]        c_idx;
    logic                 cell_in;
    logic [CMP_W-1:0]     x0_calc, y0_calc;
    logic [CMP_W-1:0]     x1, y1, qx_e, qy_e, qx1, qy1;
    logic                 overlap;

    rtc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd.rect_x),
        .divisor  (cfg.tile_w),
        .busy     (x_busy),
        .quotient (cx)
    );

    rtc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cmd.rect_y),
        .divisor  (cfg.tile_h),
        .busy     (y_busy),
        .quotient (cy)
    );

    assign rows_lim = (LIM_W'(cfg.map_rows) > LIM_W'(MAX_MAP_ROWS)) ?
                      LIM_W'(MAX_MAP_ROWS) : LIM_W'(cfg.map_rows);
    assign cols_lim = (LIM_W'(cfg.map_cols) > LIM_W'(MAX_MAP_COLS)) ?
                      LIM_W'(MAX_MAP_COLS) : LIM_W'(cfg.map_cols);

    // neighbour cell, offset by one so that the row/column above the corner is 0
    assign rr    = {1'b0, cy} + CELL_W'(dr_reg);
    assign cc    = {1'b0, cx} + CELL_W'(dc_reg);
    assign rr_m1 = rr - 1'b1;
    assign cc_m1 = cc - 1'b1;
    assign r_idx = rr_m1[RW-1:0];
    assign c_idx = cc_m1[CW-1:0];

    // inside the configured map and inside storage; cells beyond storage are empty
    assign cell_in = (rr != '0) && (cc != '0) &&
                     (rr <= CELL_W'(rows_lim)) && (cc <= CELL_W'(cols_lim)) &&
                     (rr <= CELL_W'(STORE_ROWS)) && (cc <= CELL_W'(STORE_COLS));

    assign rd_addr = ADDR_W'(r_idx * STORE_COLS + c_idx);
    assign x0_calc = CMP_W'(c_idx) * CMP_W'(cfg.tile_w);
    assign y0_calc = CMP_W'(r_idx) * CMP_W'(cfg.tile_h);

    assign x1      = x0_reg + CMP_W'(cfg.tile_w);
    assign y1      = y0_reg + CMP_W'(cfg.tile_h);
    assign qx_e    = CMP_W'(qx_reg);
    assign qy_e    = CMP_W'(qy_reg);
    assign qx1     = qx_e + CMP_W'(qw_reg);
    assign qy1     = qy_e + CMP_W'(qh_reg);
    // touching edges do not count
    assign overlap = (qx_e < x1) && (qx1 > x0_reg) && (qy_e < y1) && (qy1 > y0_reg);

    assign take_query = (state_reg == ST_IDLE) && cmd_valid && (cmd.op == OP_QUERY);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        chk_pend_next  = 1'b0;
        hit_acc_next   = hit_acc_reg |
                         (chk_pend_reg && chk_in_reg && rd_data_reg && overlap);
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        mem_we         = 1'b0;
        mem_waddr      = clr_addr_reg;
        mem_wdata      = 1'b0;
        div_start      = 1'b0;
        status.cmd_ready = (state_reg == ST_IDLE);
        status.clearing  = (state_reg == ST_CLEAR);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(cmd.tile_row * STORE_COLS + cmd.tile_col);
                        mem_wdata = cmd.tile_solid;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!x_busy && !y_busy)
                begin
                    dr_next      = '0;
                    dc_next      = '0;
                    hit_acc_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                chk_pend_next = 1'b1;
                if (dc_reg == NBR_LAST)
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 1'b1;
                    if (dr_reg == NBR_LAST)
                    begin
                        state_next = ST_TAIL;
                    end
                end
                else
                begin
                    dc_next = dc_reg + 1'b1;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = hit_acc_reg && !zero_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            dr_reg        <= '0;
            dc_reg        <= '0;
            chk_pend_reg  <= 1'b0;
            hit_acc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            dr_reg        <= dr_next;
            dc_reg        <= dc_next;
            chk_pend_reg  <= chk_pend_next;
            hit_acc_reg   <= hit_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        chk_in_reg <= cell_in;
        x0_reg     <= x0_calc;
        y0_reg     <= y0_calc;
        if (take_query)
        begin
            qx_reg   <= cmd.rect_x;
            qy_reg   <= cmd.rect_y;
            qw_reg   <= cmd.rect_w;
            qh_reg   <= cmd.rect_h;
            zero_reg <= (cfg.tile_w == '0) || (cfg.tile_h == '0);
        end
    end

    // tile map: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_hit    = hit_reg;

endmodule

`default_nettype wire

/* rtl/rect_tilemap_collision_core.sv */
// Query: the back end runs both bit-serial dividers, then 9 tile map reads over the
// 3x3 neighbourhood, then control states, before the result. A tile write is done
// directly in the idle state, with no further back-end state.
// A two-entry command queue and the result register let each side stall alone.
// Reset (rst_n, async, active low) restores the registers to 73/60/11/10 and starts a
// clearing pass over every stored tile (at most 16 x 16), s_tready low.
`timescale 1ns / 1ps
`default_nettype none

module rect_tilemap_collision_core #(
    parameter int MAX_MAP_COLS = 16,
    parameter int MAX_MAP_ROWS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [rtc_pkg::DIM_W-1:0]       cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // rect_x[11:0], rect_y[23:12], rect_w[31:24], rect_h[39:32],
    // tile_row[43:40], tile_col[47:44], tile_solid[48], zero fill[55:49]
    input  wire logic [rtc_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[0]
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // hit[0], zero fill[7:1]
    output logic [rtc_pkg::M_TDATA_W-1:0]        m_tdata
);
    import rtc_pkg::*;

    cfg_t           cfg_reg;
    back_status_t   status;
    logic           cmd_valid;
    cmd_t           cmd;
    logic           hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_w   <= DIM_W'(73);
            cfg_reg.tile_h   <= DIM_W'(60);
            cfg_reg.map_cols <= MAPSZ_W'(11);
            cfg_reg.map_rows <= MAPSZ_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_TILE_WIDTH:  cfg_reg.tile_w   <= cfg_wdata;
                REG_TILE_HEIGHT: cfg_reg.tile_h   <= cfg_wdata;
                REG_MAP_COLS:    cfg_reg.map_cols <= cfg_wdata[MAPSZ_W-1:0];
                REG_MAP_ROWS:    cfg_reg.map_rows <= cfg_wdata[MAPSZ_W-1:0];
                default:         cfg_reg          <= cfg_reg;
            endcase
        end
    end

    rtc_front #(
        .MAX_MAP_ROWS (MAX_MAP_ROWS),
        .MAX_MAP_COLS (MAX_MAP_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .status    (status),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    rtc_back #(
        .MAX_MAP_ROWS (MAX_MAP_ROWS),
        .MAX_MAP_COLS (MAX_MAP_COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_hit     (hit)
    );

    assign m_tdata = {{(M_TDATA_W-1){1'b0}}, hit};

endmodule

`default_nettype wire

/* rtl/rtc_checker.sv */
// Port-level checker for the tile-map collision core, bound to the top level.
// Depends on rtc_pkg and rect_tilemap_collision_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "rect_tilemap_collision_core_assert.svh"

module rtc_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [rtc_pkg::M_TDATA_W-1:0]   m_tdata
);
    import rtc_pkg::*;

    // queries accepted whose result is not yet delivered
    logic [2:0] pend_reg, pend_next;
    logic       q_acc;
    logic       r_acc;

    assign q_acc = s_tvalid && s_tready && (s_tuser == OP_QUERY);
    assign r_acc = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (q_acc && !r_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (r_acc && !q_acc)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `RTC_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
    `RTC_ASSERT_IMP(a_out_pad, clk, rst_n, m_tvalid, m_tdata[7:1] == 7'd0, "result padding not zero")
    `RTC_ASSERT_IMP(a_no_orphan, clk, rst_n, m_tvalid, pend_reg != 3'd0, "result without a pending query")
    `RTC_ASSERT_IMP(a_pend_bound, clk, rst_n, 1'b1, pend_reg <= 3'd4, "too many queries in flight")

endmodule

bind rect_tilemap_collision_core rtc_checker u_rtc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
